### rtl/hvd_pkg.sv
// hvd_pkg: shared constants for the haversine distance pipeline
// cordic arctangent table, fixed-point scale factors and stage counts
// no dependencies
package hvd_pkg;

    localparam int STEPS      = 30;
    localparam int ROOT_STEPS = 31;
    localparam int CW         = 34;
    localparam int TW         = 32;
    localparam int VW         = 54;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] RECIP180 = 32'((64'd1 << 39) / 180);

    localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

    localparam logic [25:0] RADIUS_RESET = 26'd6371000;

    localparam logic [31:0] ATAN_TAB [STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // sine/cosine unit: six reduction stages, the rotations, one output stage
    localparam int SC_LAT = 6 + STEPS + 1;

    // zero flag travels from the clamp register to the output stage
    localparam int ZD_LAT = 1 + ROOT_STEPS + 1 + STEPS;

    localparam int TOP_LAT = 1 + SC_LAT + 4 + ZD_LAT + 1;

endpackage

### rtl/hvd_sincos.sv
// hvd_sincos: pipelined sine and cosine of an angle in fixed-point degrees
// range fold, exact degree to radian scaling, then a rotation cordic
// depends on hvd_pkg
module hvd_sincos #(
    parameter int ANG_W = 29,
    parameter int FRAC  = 21
) (
    input  logic                        i_clk,
    input  logic signed [ANG_W-1:0]     i_ang,
    output logic signed [hvd_pkg::TW-1:0] o_cos,
    output logic signed [hvd_pkg::TW-1:0] o_sin
);

    localparam int RW = ((ANG_W > FRAC + 9) ? ANG_W : FRAC + 9) + 2;
    localparam int MW = FRAC + 7;
    localparam int NW = MW + 32;
    localparam int DW = FRAC + 10;
    localparam int CW = hvd_pkg::CW;
    localparam int TW = hvd_pkg::TW;
    localparam int STEPS = hvd_pkg::STEPS;

    localparam logic signed [RW-1:0] FULL = RW'(longint'(360) << FRAC);
    localparam logic signed [RW-1:0] HALF = RW'(longint'(180) << FRAC);
    localparam logic signed [RW-1:0] QUAR = RW'(longint'(90) << FRAC);
    localparam logic [DW-1:0] D1 = DW'(longint'(180) << FRAC);
    localparam logic [DW-1:0] D2 = DW'(longint'(360) << FRAC);
    localparam logic [DW-1:0] D3 = DW'(longint'(540) << FRAC);

    logic signed [RW-1:0] a_ext;
    logic signed [RW-1:0] n_r1;
    logic signed [RW-1:0] r_r1;
    logic signed [RW-1:0] fold;
    logic signed [RW-1:0] fold_abs;
    logic                 n_neg;
    logic [MW-1:0]        r_mag;
    logic                 r_neg2, r_zn2, r_neg3, r_zn3, r_neg4, r_zn4, r_neg5, r_zn5;
    logic [NW-1:0]        r_n3;
    logic [NW-1:0]        r_n4;
    logic [31:0]          r_qe4;
    logic [31:0]          r_qe5;
    logic [63:0]          q_prod;
    logic [NW-1:0]        q_back;
    logic [NW-1:0]        rem_full;
    logic [DW-1:0]        r_rem;
    logic [1:0]           q_inc;
    logic [CW-1:0]        q_fix;
    logic signed [CW-1:0] r_x [0:STEPS];
    logic signed [CW-1:0] r_y [0:STEPS];
    logic signed [CW-1:0] r_z [0:STEPS];
    logic                 r_cneg [0:STEPS];
    logic signed [CW-1:0] cos_full;
    logic signed [TW-1:0] r_cos;
    logic signed [TW-1:0] r_sin;

    // wrap into -180..180 degrees
    always_comb begin
        a_ext = RW'(i_ang);
        if (a_ext < 0 && a_ext <= -HALF) begin
            n_r1 = a_ext + FULL;
        end else if (a_ext > HALF) begin
            n_r1 = a_ext - FULL;
        end else begin
            n_r1 = a_ext;
        end
    end

    // fold into -90..90 degrees
    always_comb begin
        n_neg = 1'b0;
        fold  = r_r1;
        if (r_r1 > QUAR) begin
            fold  = HALF - r_r1;
            n_neg = 1'b1;
        end else if (r_r1 < -QUAR) begin
            fold  = -HALF - r_r1;
            n_neg = 1'b1;
        end
        fold_abs = (fold < 0) ? -fold : fold;
    end

    // quotient estimate by reciprocal, then remainder correction
    assign q_prod   = 64'(r_n3[FRAC+7 +: 32]) * 64'(hvd_pkg::RECIP180);
    assign q_back   = (NW'(r_qe4) * NW'(180)) << FRAC;
    assign rem_full = r_n4 - q_back;
    assign q_inc    = 2'(r_rem >= D1) + 2'(r_rem >= D2) + 2'(r_rem >= D3);
    assign q_fix    = CW'(r_qe5) + CW'(q_inc);

    always_ff @(posedge i_clk) begin
        r_r1   <= n_r1;
        r_mag  <= fold_abs[MW-1:0];
        r_neg2 <= n_neg;
        r_zn2  <= fold < 0;
        r_n3   <= NW'(r_mag) * NW'(hvd_pkg::PI_Q30);
        r_neg3 <= r_neg2;
        r_zn3  <= r_zn2;
        r_n4   <= r_n3;
        r_qe4  <= q_prod[63:32];
        r_neg4 <= r_neg3;
        r_zn4  <= r_zn3;
        r_rem  <= rem_full[DW-1:0];
        r_qe5  <= r_qe4;
        r_neg5 <= r_neg4;
        r_zn5  <= r_zn4;
        r_x[0]    <= CW'(hvd_pkg::GAIN_Q30);
        r_y[0]    <= '0;
        r_z[0]    <= r_zn5 ? -signed'(q_fix) : signed'(q_fix);
        r_cneg[0] <= r_neg5;
    end

    // rotation cordic, one step per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        logic signed [CW-1:0] atan_v;
        assign atan_v = signed'(CW'(hvd_pkg::ATAN_TAB[i]));
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_v;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_v;
            end
            r_cneg[i+1] <= r_cneg[i];
        end
    end

    assign cos_full = r_cneg[STEPS] ? -r_x[STEPS] : r_x[STEPS];

    always_ff @(posedge i_clk) begin
        r_cos <= cos_full[TW-1:0];
        r_sin <= r_y[STEPS][TW-1:0];
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### rtl/haversine_distance.sv
// haversine_distance: great-circle distance between two positions
// top level; sine/cosine units, products, two integer roots, vectoring cordic
// depends on hvd_pkg and hvd_sincos
//
// A request carries two latitude/longitude pairs in degrees with 20 fraction
// bits and is taken at every rising edge where i_start is high; o_busy stays
// low, so a new request can enter in every cycle.
// The result appears on o_distance for one cycle, marked by o_done; one
// result leaves per cycle at full rate. The path holds the two 30-step
// cordic chains and the 31-step root chain, each step a register stage.
// The receiver cannot stall; results are presented once and never held.
// The radius register is written through i_cfg_valid/o_cfg_ready/i_cfg_data
// and should only change while no request is in flight.
// Synchronous reset clears the in-flight strobes, so nothing emerges after
// reset, and loads the default radius of 6371000.
module haversine_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [28:0] i_lon_b,
    output logic               o_done,
    output logic [27:0]        o_distance,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [25:0]        i_cfg_data
);

    localparam int STEPS = hvd_pkg::STEPS;
    localparam int RS    = hvd_pkg::ROOT_STEPS;
    localparam int TW    = hvd_pkg::TW;
    localparam int CW    = hvd_pkg::CW;
    localparam int VW    = hvd_pkg::VW;
    localparam int LAT   = hvd_pkg::TOP_LAT;
    localparam int ZD    = hvd_pkg::ZD_LAT;

    logic [25:0]          r_radius;
    logic [LAT-1:0]       r_vld;
    logic [ZD-1:0]        r_zdl;

    logic signed [27:0]   r_lat_a;
    logic signed [27:0]   r_lat_b;
    logic signed [28:0]   r_dlat;
    logic signed [29:0]   r_dlon;

    logic signed [TW-1:0] cos_a, cos_b, sin_dlat, sin_dlon;

    logic signed [63:0]   p_cc;
    logic signed [63:0]   p_ss;
    logic signed [65:0]   p_t;
    logic signed [65:0]   p_ts;
    logic signed [CW-1:0] r_p;
    logic signed [63:0]   r_s1sq1, r_s1sq2, r_s1sq3;
    logic signed [TW-1:0] r_s2_1, r_s2_2;
    logic signed [CW-1:0] r_t;
    logic signed [65:0]   r_ts;
    logic signed [66:0]   a_sum;
    logic [60:0]          a_clamp;
    logic [60:0]          r_a;
    logic                 r_az;

    logic [61:0]          r_qv_s [0:RS];
    logic [61:0]          r_qr_s [0:RS];
    logic [61:0]          r_qv_c [0:RS];
    logic [61:0]          r_qr_c [0:RS];

    logic signed [VW-1:0] r_vx [0:STEPS];
    logic signed [VW-1:0] r_vy [0:STEPS];
    logic signed [CW-1:0] r_vz [0:STEPS];

    logic [30:0]          ang;
    logic [56:0]          d_prod;
    logic [27:0]          r_dist;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hvd_pkg::RADIUS_RESET;
            r_vld    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat_a <= i_lat_a;
        r_lat_b <= i_lat_b;
        r_dlat  <= 29'(i_lat_b) - 29'(i_lat_a);
        r_dlon  <= 30'(i_lon_b) - 30'(i_lon_a);
    end

    hvd_sincos #(.ANG_W(28), .FRAC(20)) u_trig_lat_a (
        .i_clk (i_clk),
        .i_ang (r_lat_a),
        .o_cos (cos_a),
        .o_sin ()
    );

    hvd_sincos #(.ANG_W(28), .FRAC(20)) u_trig_lat_b (
        .i_clk (i_clk),
        .i_ang (r_lat_b),
        .o_cos (cos_b),
        .o_sin ()
    );

    // half differences: the difference read with one more fraction bit
    hvd_sincos #(.ANG_W(29), .FRAC(21)) u_trig_dlat (
        .i_clk (i_clk),
        .i_ang (r_dlat),
        .o_cos (),
        .o_sin (sin_dlat)
    );

    hvd_sincos #(.ANG_W(30), .FRAC(21)) u_trig_dlon (
        .i_clk (i_clk),
        .i_ang (r_dlon),
        .o_cos (),
        .o_sin (sin_dlon)
    );

    assign p_cc = cos_a * cos_b;
    assign p_ss = sin_dlat * sin_dlat;
    assign p_t  = r_p * r_s2_1;
    assign p_ts = r_t * r_s2_2;
    assign a_sum = 67'(r_s1sq3) + 67'(r_ts);

    always_comb begin
        if (a_sum < 0) begin
            a_clamp = '0;
        end else if (a_sum > 67'(hvd_pkg::ONE_Q60)) begin
            a_clamp = hvd_pkg::ONE_Q60;
        end else begin
            a_clamp = a_sum[60:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= p_cc[63:30];
        r_s1sq1 <= p_ss;
        r_s2_1  <= sin_dlon;
        r_t     <= p_t[63:30];
        r_s1sq2 <= r_s1sq1;
        r_s2_2  <= r_s2_1;
        r_ts    <= p_ts;
        r_s1sq3 <= r_s1sq2;
        r_a     <= a_clamp;
        r_az    <= a_clamp == '0;
        r_zdl   <= {r_zdl[ZD-2:0], r_az};
        r_qv_s[0] <= 62'(r_a);
        r_qv_c[0] <= 62'(hvd_pkg::ONE_Q60 - r_a);
        r_qr_s[0] <= '0;
        r_qr_c[0] <= '0;
    end

    // restoring square roots, two radicand bits per stage
    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
        logic [61:0] trial_s;
        logic [61:0] trial_c;
        assign trial_s = r_qr_s[k] + BIT;
        assign trial_c = r_qr_c[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_qv_s[k] >= trial_s) begin
                r_qv_s[k+1] <= r_qv_s[k] - trial_s;
                r_qr_s[k+1] <= (r_qr_s[k] >> 1) + BIT;
            end else begin
                r_qv_s[k+1] <= r_qv_s[k];
                r_qr_s[k+1] <= r_qr_s[k] >> 1;
            end
            if (r_qv_c[k] >= trial_c) begin
                r_qv_c[k+1] <= r_qv_c[k] - trial_c;
                r_qr_c[k+1] <= (r_qr_c[k] >> 1) + BIT;
            end else begin
                r_qv_c[k+1] <= r_qv_c[k];
                r_qr_c[k+1] <= r_qr_c[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx[0] <= signed'(VW'({r_qr_c[RS][30:0], 20'b0}));
        r_vy[0] <= signed'(VW'({r_qr_s[RS][30:0], 20'b0}));
        r_vz[0] <= '0;
    end

    // vectoring cordic for the arctangent
    for (genvar j = 0; j < STEPS; j++) begin : g_vec
        logic signed [CW-1:0] atan_v;
        assign atan_v = signed'(CW'(hvd_pkg::ATAN_TAB[j]));
        always_ff @(posedge i_clk) begin
            if (r_vy[j] > 0) begin
                r_vx[j+1] <= r_vx[j] + (r_vy[j] >>> j);
                r_vy[j+1] <= r_vy[j] - (r_vx[j] >>> j);
                r_vz[j+1] <= r_vz[j] + atan_v;
            end else begin
                r_vx[j+1] <= r_vx[j] - (r_vy[j] >>> j);
                r_vy[j+1] <= r_vy[j] + (r_vx[j] >>> j);
                r_vz[j+1] <= r_vz[j] - atan_v;
            end
        end
    end

    assign ang    = (r_vz[STEPS] < 0) ? '0 : r_vz[STEPS][30:0];
    assign d_prod = 57'(ang) * 57'(r_radius);

    always_ff @(posedge i_clk) begin
        r_dist <= r_zdl[ZD-1] ? '0 : d_prod[56:29];
    end

    assign o_done     = r_vld[LAT-1];
    assign o_distance = r_dist;

endmodule

### verif/haversine_distance_tb.sv
// haversine_distance_tb: self-checking testbench for the haversine distance block
// predicts every distance in fixed point and compares each strobed result in order
// depends on hvd_pkg and the haversine_distance rtl
module haversine_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LAT_MAX = 94371840;
    localparam longint LON_MAX = 188743680;
    localparam int     DRAIN   = hvd_pkg::TOP_LAT + 20;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [27:0] i_lat_a = '0;
    logic signed [27:0] i_lat_b = '0;
    logic signed [28:0] i_lon_a = '0;
    logic signed [28:0] i_lon_b = '0;
    logic               o_done;
    logic [27:0]        o_distance;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [25:0]        i_cfg_data = '0;

    logic [25:0] radius = hvd_pkg::RADIUS_RESET;
    logic [27:0] dist_q[$];
    int          n_requests = 0;
    int          n_checked = 0;
    int          n_mismatch = 0;

    haversine_distance dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic void sin_cos(input longint ang, input int frac,
                                    output longint cs, output longint sn);
        longint full, half, quar, r, x, y, z, nx, ny;
        bit     neg_cos;
        full = longint'(360) << frac;
        half = longint'(180) << frac;
        quar = longint'(90) << frac;
        neg_cos = 1'b0;
        r = ang % full;
        if (r < 0) r += full;
        if (r > half) r -= full;
        if (r > quar) begin
            r = half - r;
            neg_cos = 1'b1;
        end else if (r < -quar) begin
            r = -half - r;
            neg_cos = 1'b1;
        end
        z = r * longint'(hvd_pkg::PI_Q30) / half;
        x = longint'(hvd_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < hvd_pkg::STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(hvd_pkg::ATAN_TAB[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(hvd_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        cs = neg_cos ? -x : x;
        sn = y;
    endfunction

    function automatic longint floor_root(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arc_angle(input longint x, input longint y);
        longint z, nx, ny;
        z = 0;
        for (int i = 0; i < hvd_pkg::STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(hvd_pkg::ATAN_TAB[i]);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(hvd_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [27:0] great_circle(input logic signed [27:0] lat_a,
            input logic signed [27:0] lat_b, input logic signed [28:0] lon_a,
            input logic signed [28:0] lon_b, input logic [25:0] rad);
        longint cos_a, sin_a, cos_b, sin_b, unused, s_lat, s_lon, p, t, hav, sq, cq, ang;
        longint unsigned d;
        sin_cos(longint'(lat_a), 20, cos_a, sin_a);
        sin_cos(longint'(lat_b), 20, cos_b, sin_b);
        sin_cos(longint'(lat_b) - longint'(lat_a), 21, unused, s_lat);
        sin_cos(longint'(lon_b) - longint'(lon_a), 21, unused, s_lon);
        p = (cos_a * cos_b) >>> 30;
        t = (p * s_lon) >>> 30;
        hav = s_lat * s_lat + t * s_lon;
        if (hav < 0) hav = 0;
        if (hav > longint'(hvd_pkg::ONE_Q60)) hav = longint'(hvd_pkg::ONE_Q60);
        if (hav == 0) return '0;
        sq = floor_root(longint'(hav));
        cq = floor_root(longint'(hvd_pkg::ONE_Q60) - hav);
        ang = arc_angle(cq << 20, sq << 20);
        d = (longint'(ang) * 2 * longint'(rad)) >> 30;
        return d[27:0];
    endfunction

    // request capture
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            dist_q.push_back(great_circle(i_lat_a, i_lat_b, i_lon_a, i_lon_b, radius));
            n_requests++;
        end
    end

    // result check
    always @(posedge i_clk) begin
        logic [27:0] want;
        if (i_rst_n && o_done) begin
            if (dist_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %0d", o_distance);
            end else begin
                want = dist_q.pop_front();
                n_checked++;
                if (want !== o_distance) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("distance mismatch: expected %0d got %0d", want, o_distance);
                end
            end
        end
    end

    task automatic send_pos(input logic signed [27:0] la, input logic signed [27:0] lb,
                            input logic signed [28:0] oa, input logic signed [28:0] ob,
                            input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_lat_a <= la;
        i_lat_b <= lb;
        i_lon_a <= oa;
        i_lon_b <= ob;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_radius(input logic [25:0] r);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius = r;
    endtask

    task automatic test_directed();
        send_pos(0, 0, 0, 0, 0);
        send_pos(28'sd94371840, -28'sd94371840, 0, 0, 0);
        send_pos(0, 0, -29'sd188743680, 29'sd188743680, 0);
        send_pos(0, 0, 0, 29'sd188743680, 0);
        send_pos(28'sd94371840, 28'sd94371840, 0, 29'sd188743680, 0);
        send_pos(-28'sd94371840, 28'sd94371840, 29'sd188743680, -29'sd188743680, 0);
        send_pos(28'sd1, 0, 0, 29'sd1, 0);
        send_pos(0, 0, 0, 29'sd1, 0);
        send_pos(28'sd41000000, 28'sd41000000, 29'sd10000000, 29'sd10000000, 0);
        // latitudes beyond the pole
        send_pos(28'h7FFFFFF, 28'h8000000, 29'h0FFFFFFF, 29'h10000000, 0);
        send_pos(28'h8000000, 28'h8000000, 29'h10000000, 29'h0FFFFFFF, 0);
        send_pos(28'sd120000000, -28'sd120000000, 29'sd5000000, 29'sd200000000, 0);
        send_pos(28'sd100000000, 28'sd110000000, 0, 29'sd188743680, 0);
        send_pos(28'h7FFFFFF, 28'h7FFFFFF, 29'h0FFFFFFF, 29'h0FFFFFFF, 0);
        send_pos(28'sd53000000, -28'sd53000000, 29'sd10000000, -29'sd178000000, 0);
        send_pos(-28'sd47185920, 28'sd47185920, 29'sd94371840, -29'sd94371840, 0);
        drain();
    endtask

    task automatic test_random(input int n, input int idle_pct);
        logic signed [27:0] la, lb;
        logic signed [28:0] oa, ob;
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            la = 28'($urandom_range(2 * LAT_MAX) - LAT_MAX);
            oa = 29'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
            if (sel < 70) begin
                lb = 28'($urandom_range(2 * LAT_MAX) - LAT_MAX);
                ob = 29'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
            end else if (sel < 88) begin
                // nearby points, down to identical ones
                lb = 28'(la + 28'($urandom_range(2000) - 1000) * $urandom_range(1));
                ob = 29'(oa + 29'($urandom_range(2000) - 1000) * $urandom_range(1));
            end else begin
                la = 28'($urandom);
                lb = 28'($urandom);
                oa = 29'($urandom);
                ob = 29'($urandom);
            end
            send_pos(la, lb, oa, ob, idle_pct);
            if ($urandom_range(99) < 3) begin
                i_start <= 1'b0;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 0);
        set_radius(26'd1);
        test_directed();
        test_random(300, 61);
        set_radius(26'h3FFFFFF);
        test_directed();
        test_random(300, 35);
        set_radius(26'd0);
        test_random(40, 0);
        set_radius(26'($urandom_range(67108863, 1)));
        test_random(300, 0);
        set_radius(hvd_pkg::RADIUS_RESET);
        test_random(300, 61);
        $display("%0d requests sent, %0d distances checked, %0d mismatches", n_requests,
                 n_checked, n_mismatch);
        $display("covered radius extremes, zero radius, poles and beyond, gaps of 0/35/61 pct");
        if (n_mismatch == 0 && dist_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end
endmodule

### sim.f
rtl/hvd_pkg.sv
rtl/hvd_sincos.sv
rtl/haversine_distance.sv
verif/haversine_distance_tb.sv
